>>> hdl/tle_pkg.sv
package tle_pkg;

    localparam int LINE_CAPACITY_DEF = 64;
    localparam int CFG_IDX_W         = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DELIVER_LINES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIVER_CONTROLS = 2'd1;

    localparam logic [7:0] BYTE_BS       = 8'h08;
    localparam logic [7:0] BYTE_TAB      = 8'h09;
    localparam logic [7:0] BYTE_LF       = 8'h0A;
    localparam logic [7:0] BYTE_CR       = 8'h0D;
    localparam logic [7:0] BYTE_ESC      = 8'h1B;
    localparam logic [7:0] BYTE_SPACE    = 8'h20;
    localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
    localparam logic [7:0] BYTE_TILDE    = 8'h7E;

    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_CRLF = 2'd1,
        KIND_LINE = 2'd2,
        KIND_CTRL = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        DSEL_BYTE  = 3'd0,
        DSEL_BS    = 3'd1,
        DSEL_SPACE = 3'd2,
        DSEL_ZERO  = 3'd3,
        DSEL_RAM   = 3'd4
    } t_dsel;

    typedef struct packed {
        logic  latch_byte;
        logic  rd_look;
        logic  rd_line;
        logic  wr_store;
        logic  fill_inc;
        logic  fill_dec;
        logic  fill_clr;
        logic  esc_set;
        logic  esc_clr;
        logic  idx_clr;
        logic  idx_inc;
        logic  out_load;
        t_kind out_kind;
        t_dsel out_sel;
        logic  out_last;
    } t_cmd;

    typedef struct packed {
        logic is_bs;
        logic is_eol;
        logic is_esc;
        logic is_lbr;
        logic is_print;
        logic is_tab;
        logic prev_esc;
        logic fill_zero;
        logic fill_full;
        logic idx_last;
        logic esc_armed;
        logic deliver_lines;
        logic deliver_controls;
        logic out_free;
    } t_status;

endpackage

>>> hdl/terminal_line_editor.sv
// channel   direction  handshake                  payload
// rx        in         i_valid / o_ready          i_rx_byte[7:0]
// result    out        o_valid / i_ready          o_kind[1:0], o_data[7:0], o_last
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index[1:0], i_cfg_data
//
// A byte passes accept, buffer lookup and decode, then emits each echo or
// control word it causes; a line end emits the CRLF word, then reads and
// emits each delivered line byte in turn through the buffer's single read port.
// Reset is synchronous; no buffer clearing pass, the block is ready at once.
// A stalled result word holds in the output register and stops the sequencer.
module terminal_line_editor #(
    parameter int LINE_CAPACITY = tle_pkg::LINE_CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_kind,
    output logic [7:0]                    o_data,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tle_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                          i_cfg_data
);

    tle_pkg::t_cmd    cmd;
    tle_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    tle_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tle_datapath #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_kind      (o_kind),
        .o_data      (o_data),
        .o_last      (o_last)
    );

endmodule

>>> hdl/tle_ram.sv
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/tle_datapath.sv
module tle_datapath #(
    parameter int LINE_CAPACITY = tle_pkg::LINE_CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tle_pkg::t_cmd                 i_cmd,
    output tle_pkg::t_status              o_status,
    input  logic [7:0]                    i_rx_byte,
    input  logic                          i_cfg_valid,
    input  logic [tle_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                          i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [1:0]                    o_kind,
    output logic [7:0]                    o_data,
    output logic                          o_last
);

    localparam int AW = $clog2(LINE_CAPACITY);

    logic [7:0]    r_byte;
    logic [AW-1:0] r_fill;
    logic [AW-1:0] r_idx;
    logic          r_esc;
    logic          r_deliver_lines;
    logic          r_deliver_controls;
    logic          r_out_valid;
    logic [1:0]    r_kind;
    logic [7:0]    r_data;
    logic          r_last;
    logic [7:0]    n_data;
    logic [AW-1:0] look_addr;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    logic          fill_zero;

    assign fill_zero = (r_fill == '0);
    assign look_addr = fill_zero ? '0 : r_fill - AW'(1);
    assign raddr     = i_cmd.rd_line ? r_idx : look_addr;

    tle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAPACITY)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_store),
        .i_waddr (r_fill),
        .i_wdata (r_byte),
        .i_re    (i_cmd.rd_look | i_cmd.rd_line),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill             <= '0;
            r_esc              <= 1'b0;
            r_deliver_lines    <= 1'b1;
            r_deliver_controls <= 1'b1;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cmd.fill_clr) begin
                r_fill <= '0;
            end else if (i_cmd.fill_inc) begin
                r_fill <= r_fill + AW'(1);
            end else if (i_cmd.fill_dec) begin
                r_fill <= r_fill - AW'(1);
            end
            if (i_cmd.esc_set) begin
                r_esc <= 1'b1;
            end else if (i_cmd.esc_clr) begin
                r_esc <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tle_pkg::CFG_DELIVER_LINES:    r_deliver_lines    <= i_cfg_data;
                    tle_pkg::CFG_DELIVER_CONTROLS: r_deliver_controls <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        case (i_cmd.out_sel)
            tle_pkg::DSEL_BYTE:  n_data = r_byte;
            tle_pkg::DSEL_BS:    n_data = tle_pkg::BYTE_BS;
            tle_pkg::DSEL_SPACE: n_data = tle_pkg::BYTE_SPACE;
            tle_pkg::DSEL_RAM:   n_data = rdata;
            default:             n_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_byte) begin
            r_byte <= i_rx_byte;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.out_load) begin
            r_kind <= i_cmd.out_kind;
            r_data <= n_data;
            r_last <= i_cmd.out_last;
        end
    end

    always_comb begin
        o_status.is_bs            = (r_byte == tle_pkg::BYTE_BS);
        o_status.is_eol           = (r_byte == tle_pkg::BYTE_CR) || (r_byte == tle_pkg::BYTE_LF);
        o_status.is_esc           = (r_byte == tle_pkg::BYTE_ESC);
        o_status.is_lbr           = (r_byte == tle_pkg::BYTE_LBRACKET);
        o_status.is_print         = (r_byte >= tle_pkg::BYTE_SPACE) &&
                                    (r_byte <= tle_pkg::BYTE_TILDE);
        o_status.is_tab           = (r_byte == tle_pkg::BYTE_TAB);
        o_status.prev_esc         = (rdata == tle_pkg::BYTE_ESC);
        o_status.fill_zero        = fill_zero;
        o_status.fill_full        = (r_fill == AW'(LINE_CAPACITY - 1));
        o_status.idx_last         = (r_idx == look_addr);
        o_status.esc_armed        = r_esc;
        o_status.deliver_lines    = r_deliver_lines;
        o_status.deliver_controls = r_deliver_controls;
        o_status.out_free         = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_data      = r_data;
    assign o_last      = r_last;

endmodule

>>> hdl/tle_ctrl.sv
module tle_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tle_pkg::t_status i_status,
    output tle_pkg::t_cmd    o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_LOOK   = 12'b0000_0000_0010,
        S_DECIDE = 12'b0000_0000_0100,
        S_CTRL   = 12'b0000_0000_1000,
        S_ECHO   = 12'b0000_0001_0000,
        S_TABE   = 12'b0000_0010_0000,
        S_BS1    = 12'b0000_0100_0000,
        S_BS2    = 12'b0000_1000_0000,
        S_BS3    = 12'b0001_0000_0000,
        S_CRLF   = 12'b0010_0000_0000,
        S_LREAD  = 12'b0100_0000_0000,
        S_LEMIT  = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   crlf_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready   = (r_state == S_IDLE);
    assign crlf_last = !i_status.deliver_lines || i_status.fill_zero;

    always_comb begin
        n_state          = r_state;
        o_cmd.latch_byte = 1'b0;
        o_cmd.rd_look    = 1'b0;
        o_cmd.rd_line    = 1'b0;
        o_cmd.wr_store   = 1'b0;
        o_cmd.fill_inc   = 1'b0;
        o_cmd.fill_dec   = 1'b0;
        o_cmd.fill_clr   = 1'b0;
        o_cmd.esc_set    = 1'b0;
        o_cmd.esc_clr    = 1'b0;
        o_cmd.idx_clr    = 1'b0;
        o_cmd.idx_inc    = 1'b0;
        o_cmd.out_load   = 1'b0;
        o_cmd.out_kind   = tle_pkg::KIND_ECHO;
        o_cmd.out_sel    = tle_pkg::DSEL_BYTE;
        o_cmd.out_last   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch_byte = 1'b1;
                    n_state          = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.rd_look = 1'b1;
                n_state       = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_IDLE;
                if (i_status.esc_armed) begin
                    o_cmd.esc_clr = 1'b1;
                    if (i_status.deliver_controls) begin
                        n_state = S_CTRL;
                    end
                end else if (i_status.is_bs) begin
                    if (!i_status.fill_zero) begin
                        o_cmd.fill_dec = 1'b1;
                        n_state        = S_BS1;
                    end
                end else if (i_status.is_eol) begin
                    n_state = S_CRLF;
                end else if (i_status.is_esc) begin
                    if (!i_status.fill_full) begin
                        o_cmd.wr_store = 1'b1;
                        o_cmd.fill_inc = 1'b1;
                    end
                end else if (i_status.is_lbr && !i_status.fill_zero && i_status.prev_esc) begin
                    o_cmd.esc_set  = 1'b1;
                    o_cmd.fill_dec = 1'b1;
                end else if (!i_status.fill_full && i_status.is_print) begin
                    o_cmd.wr_store = 1'b1;
                    o_cmd.fill_inc = 1'b1;
                    n_state        = S_ECHO;
                end else if (!i_status.fill_full && i_status.is_tab) begin
                    o_cmd.wr_store = 1'b1;
                    o_cmd.fill_inc = 1'b1;
                    n_state        = S_TABE;
                end
            end
            S_CTRL: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = tle_pkg::KIND_CTRL;
                    o_cmd.out_sel  = tle_pkg::DSEL_BYTE;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_ECHO: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = tle_pkg::DSEL_BYTE;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_TABE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = tle_pkg::DSEL_SPACE;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_BS1: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = tle_pkg::DSEL_BS;
                    n_state        = S_BS2;
                end
            end
            S_BS2: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = tle_pkg::DSEL_SPACE;
                    n_state        = S_BS3;
                end
            end
            S_BS3: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = tle_pkg::DSEL_BS;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_CRLF: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = tle_pkg::KIND_CRLF;
                    o_cmd.out_sel  = tle_pkg::DSEL_ZERO;
                    o_cmd.out_last = crlf_last;
                    o_cmd.idx_clr  = 1'b1;
                    if (crlf_last) begin
                        o_cmd.fill_clr = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_state = S_LREAD;
                    end
                end
            end
            S_LREAD: begin
                o_cmd.rd_line = 1'b1;
                n_state       = S_LEMIT;
            end
            S_LEMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = tle_pkg::KIND_LINE;
                    o_cmd.out_sel  = tle_pkg::DSEL_RAM;
                    o_cmd.out_last = i_status.idx_last;
                    if (i_status.idx_last) begin
                        o_cmd.fill_clr = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_LREAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
